@@ sv/ccfr_pkg.sv @@
// Shared types, constants and the CRC-16-CCITT byte step for the
// COBS/CRC frame receiver. No dependencies.
package ccfr_pkg;

    localparam int MAX_ENCODED  = 64;
    localparam int STORE_DEPTH  = 64;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int MIN_PAYLOAD  = 22;
    localparam int LEN_SAT      = 127;
    localparam int HEAD_BYTES   = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  VERSION_RESET = 8'd3;

    localparam logic [7:0] TYPE_A = 8'd1;
    localparam logic [7:0] TYPE_B = 8'd2;
    localparam logic [7:0] TYPE_C = 8'd3;
    localparam logic [CNT_W-1:0] LEN_TYPE_A = CNT_W'(34);
    localparam logic [CNT_W-1:0] LEN_TYPE_B = CNT_W'(32);
    localparam logic [CNT_W-1:0] LEN_TYPE_C = CNT_W'(48);

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TOO_LONG  = 3'd1,
        ERR_EMPTY     = 3'd2,
        ERR_TRUNCATED = 3'd3,
        ERR_SHORT     = 3'd4,
        ERR_CRC       = 3'd5,
        ERR_VERSION   = 3'd6,
        ERR_TYPE_SIZE = 3'd7
    } err_t;

    typedef struct packed {
        logic start;      // open a frame
        logic feed;       // decode one nonzero encoded byte
        logic latch_err;  // capture the check result
        logic idx_clear;  // restart the emit index
        logic idx_inc;    // advance the emit index
        logic rd_en;      // read payload store at the emit index
    } ccfr_cmd_t;

    typedef struct packed {
        logic byte_zero;  // incoming byte is a delimiter
        logic at_limit;   // next nonzero byte aborts the frame
        err_t err;        // check result of the closed frame
        logic last;       // emit index is on the final payload byte
    } ccfr_stat_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ sv/ccfr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ccfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/ccfr_ctrl.sv @@
// Controller state machine of the frame receiver: hunt, receive, check, error report or payload emit.
// Depends on ccfr_pkg.
module ccfr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rx_valid,
    output logic                 rx_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  ccfr_pkg::ccfr_stat_t stat,
    output ccfr_pkg::ccfr_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_HUNT     = 6'b000001,
        S_RECV     = 6'b000010,
        S_CHECK    = 6'b000100,
        S_ERR_OUT  = 6'b001000,
        S_EMIT_RD  = 6'b010000,
        S_EMIT_OUT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   rx_take;

    assign rx_stall  = !((state_reg == S_HUNT) || (state_reg == S_RECV));
    assign rx_take   = rx_valid && !rx_stall;
    assign out_valid = (state_reg == S_ERR_OUT) || (state_reg == S_EMIT_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_HUNT:
            begin
                if (rx_take && stat.byte_zero)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_RECV;
                end
            end
            S_RECV:
            begin
                if (rx_take)
                begin
                    if (stat.byte_zero)
                        state_next = S_CHECK;
                    else if (stat.at_limit)
                        state_next = S_HUNT;
                    else
                        cmd.feed = 1'b1;
                end
            end
            S_CHECK:
            begin
                cmd.latch_err = 1'b1;
                cmd.idx_clear = 1'b1;
                if (stat.err == ccfr_pkg::ERR_NONE)
                    state_next = S_EMIT_RD;
                else
                    state_next = S_ERR_OUT;
            end
            S_ERR_OUT:
            begin
                if (!out_stall)
                    state_next = S_HUNT;
            end
            S_EMIT_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (!out_stall)
                begin
                    if (stat.last)
                        state_next = S_HUNT;
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_HUNT;
        else
            state_reg <= state_next;
    end

endmodule

@@ sv/ccfr_dp.sv @@
// Datapath of the frame receiver: COBS decode, CRC, payload store, checks
// and result fields. Depends on ccfr_pkg and ccfr_ram.
module ccfr_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           rx_byte,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata,
    input  ccfr_pkg::ccfr_cmd_t  cmd,
    output ccfr_pkg::ccfr_stat_t stat,
    output logic [7:0]           payload_byte,
    output logic [5:0]           byte_index,
    output logic                 last_of_run,
    output logic                 frame_ok,
    output logic [2:0]           reject_code
);

    localparam int CW = ccfr_pkg::CNT_W;
    localparam int IW = ccfr_pkg::IDX_W;

    logic [7:0]    version_reg;
    logic [CW-1:0] enc_cnt_reg, enc_cnt_next;
    logic [7:0]    group_left_reg, group_left_next;
    logic          code_ff_reg, code_ff_next;
    logic          zero_pend_reg, zero_pend_next;
    logic [CW-1:0] len_reg, len_next;
    logic [15:0]   crc_reg, crc_next;
    logic [15:0]   tail_reg, tail_next;
    logic [7:0]    head_reg [ccfr_pkg::HEAD_BYTES];
    logic [IW-1:0] idx_reg;
    ccfr_pkg::err_t err_reg, err_chk;

    logic          push;
    logic [7:0]    push_val;
    logic [7:0]    ram_rdata;
    logic          ram_we;
    logic          type_ok;

    // COBS decode of one nonzero byte
    always_comb
    begin
        enc_cnt_next    = enc_cnt_reg;
        group_left_next = group_left_reg;
        code_ff_next    = code_ff_reg;
        zero_pend_next  = zero_pend_reg;
        push            = 1'b0;
        push_val        = rx_byte;
        if (cmd.start)
        begin
            enc_cnt_next    = '0;
            group_left_next = '0;
            code_ff_next    = 1'b0;
            zero_pend_next  = 1'b0;
        end
        else if (cmd.feed)
        begin
            enc_cnt_next = enc_cnt_reg + CW'(1);
            if (group_left_reg == 8'd0)
            begin
                push            = zero_pend_reg;
                push_val        = 8'd0;
                code_ff_next    = (rx_byte == 8'hFF);
                group_left_next = rx_byte - 8'd1;
                zero_pend_next  = (rx_byte == 8'd1);
            end
            else
            begin
                push            = 1'b1;
                group_left_next = group_left_reg - 8'd1;
                zero_pend_next  = (group_left_reg == 8'd1) && !code_ff_reg;
            end
        end
    end

    // payload push: CRC trails two bytes behind, length saturates
    always_comb
    begin
        len_next  = len_reg;
        crc_next  = crc_reg;
        tail_next = tail_reg;
        if (cmd.start)
        begin
            len_next  = '0;
            crc_next  = ccfr_pkg::CRC_INIT;
            tail_next = '0;
        end
        else if (push)
        begin
            if (len_reg >= CW'(2))
                crc_next = ccfr_pkg::crc_byte(crc_reg, tail_reg[15:8]);
            tail_next = {tail_reg[7:0], push_val};
            if (len_reg < CW'(ccfr_pkg::LEN_SAT))
                len_next = len_reg + CW'(1);
        end
    end

    assign ram_we = push && (len_reg < CW'(ccfr_pkg::STORE_DEPTH));

    ccfr_ram #(
        .WIDTH (8),
        .DEPTH (ccfr_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (len_reg[IW-1:0]),
        .wdata (push_val),
        .re    (cmd.rd_en),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg    <= ccfr_pkg::VERSION_RESET;
            enc_cnt_reg    <= '0;
            group_left_reg <= '0;
            code_ff_reg    <= 1'b0;
            zero_pend_reg  <= 1'b0;
            len_reg        <= '0;
            crc_reg        <= ccfr_pkg::CRC_INIT;
            tail_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
                version_reg <= cfg_wdata;
            enc_cnt_reg    <= enc_cnt_next;
            group_left_reg <= group_left_next;
            code_ff_reg    <= code_ff_next;
            zero_pend_reg  <= zero_pend_next;
            len_reg        <= len_next;
            crc_reg        <= crc_next;
            tail_reg       <= tail_next;
        end
    end

    // first payload bytes kept in flops for the header checks; also the latched check result and the emit index
    always_ff @(posedge clk)
    begin
        if (push && (len_reg < CW'(ccfr_pkg::HEAD_BYTES)))
            head_reg[len_reg[1:0]] <= push_val;
        if (cmd.latch_err)
            err_reg <= err_chk;
        if (cmd.idx_clear)
            idx_reg <= '0;
        else if (cmd.idx_inc)
            idx_reg <= idx_reg + IW'(1);
    end

    always_comb
    begin
        type_ok = ((head_reg[1] == ccfr_pkg::TYPE_A) && (len_reg == ccfr_pkg::LEN_TYPE_A)
                   && (head_reg[2] == 8'd1))
               || ((head_reg[1] == ccfr_pkg::TYPE_B) && (len_reg == ccfr_pkg::LEN_TYPE_B)
                   && (head_reg[2] == 8'd1))
               || ((head_reg[1] == ccfr_pkg::TYPE_C) && (len_reg == ccfr_pkg::LEN_TYPE_C)
                   && (head_reg[2] == 8'd0) && (head_reg[3] == 8'd1));
        priority if (enc_cnt_reg == '0)
            err_chk = ccfr_pkg::ERR_EMPTY;
        else if (enc_cnt_reg > CW'(ccfr_pkg::MAX_ENCODED))
            err_chk = ccfr_pkg::ERR_TOO_LONG;
        else if (group_left_reg != 8'd0)
            err_chk = ccfr_pkg::ERR_TRUNCATED;
        else if (len_reg < CW'(ccfr_pkg::MIN_PAYLOAD))
            err_chk = ccfr_pkg::ERR_SHORT;
        else if (crc_reg != {tail_reg[7:0], tail_reg[15:8]})
            err_chk = ccfr_pkg::ERR_CRC;
        else if (head_reg[0] != version_reg)
            err_chk = ccfr_pkg::ERR_VERSION;
        else if (!type_ok)
            err_chk = ccfr_pkg::ERR_TYPE_SIZE;
        else
            err_chk = ccfr_pkg::ERR_NONE;
    end

    assign stat.byte_zero = (rx_byte == 8'd0);
    assign stat.at_limit  = (enc_cnt_reg == CW'(ccfr_pkg::MAX_ENCODED + 1));
    assign stat.err       = err_chk;
    assign stat.last      = ({1'b0, idx_reg} == (len_reg - CW'(3)));

    assign frame_ok     = (err_reg == ccfr_pkg::ERR_NONE);
    assign payload_byte = frame_ok ? ram_rdata : 8'd0;
    assign byte_index   = frame_ok ? idx_reg : '0;
    assign last_of_run  = frame_ok ? stat.last : 1'b1;
    assign reject_code  = err_reg;

endmodule

@@ sv/cobs_crc_frame_receiver.sv @@
// COBS frame receiver with CRC-16-CCITT check: top level.
// After the closing zero is taken, the check state runs; then an error report is
//   offered, or the store is read and the first payload result is offered; each
//   further payload result takes a store read state and an output state, paced
//   by the single registered read port of the store.
// Throughput: 1 received byte per cycle while hunting or receiving; input is
//   stalled from the closing zero until the frame's last result is taken.
// Reset (rst_n, async, active low): hunt for an opening zero, expected_version 3.
// Depends on ccfr_pkg, ccfr_ctrl, ccfr_dp, ccfr_ram.
module cobs_crc_frame_receiver (
    input  logic       clk,
    input  logic       rst_n,
    // configuration: expected_version register
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    // received byte request channel
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    // result request channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] payload_byte,
    output logic [5:0] byte_index,
    output logic       last_of_run,
    output logic       frame_ok,
    output logic [2:0] reject_code
);

    ccfr_pkg::ccfr_cmd_t  cmd;
    ccfr_pkg::ccfr_stat_t stat;

    // Controller: sequences hunt, receive, check and result emission; holds
    // results until the downstream side takes them.
    ccfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: decodes COBS on the fly, runs the CRC two bytes behind the
    // decoded bytes so the trailer is excluded, stores the payload and forms results.
    ccfr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (rx_byte),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .stat         (stat),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .last_of_run  (last_of_run),
        .frame_ok     (frame_ok),
        .reject_code  (reject_code)
    );

endmodule
